>>> rtl/tdpt_pkg.sv
package tdpt_pkg;

  // Width of the candidate and echoed value fields on the channels.
  localparam int FIELD_WIDTH = 16;

  // Smallest divisor that the test tries.
  localparam int FIRST_DIVISOR = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_DONE
  } tdpt_state_t;

endpackage

>>> rtl/tdpt_in_if.sv
interface tdpt_in_if import tdpt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

>>> rtl/tdpt_out_if.sv
interface tdpt_out_if import tdpt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   passed;
  logic [FIELD_WIDTH-1:0] echoed_value;

  modport source (output valid, output passed, output echoed_value, input ready);
  modport sink (input valid, input passed, input echoed_value, output ready);
endinterface

>>> rtl/trial_division_prime_test.sv
// Trial-division primality tester.
// A word on the cand_ch channel carries one unsigned candidate; the block
// answers with one word on res_ch: passed and the candidate echoed back, or
// passed low and zero when some divisor in 2..candidate-1 divides it.
// Only the low min(16, VALUE_WIDTH) bits of the candidate are tested.
// One shared restoring remainder unit does all the work, one remainder bit
// per cycle, for divisors tried in turn from 2 upward. A candidate below
// three goes from the range check straight to the result; otherwise trial
// division stops at the first divisor that leaves no remainder, or, for a
// prime, when the divisor reaches the candidate.
// cand_ch.ready is high only while the block is idle, so one candidate is
// in work at a time. The result is held in registers until res_ch takes it;
// a stalled receiver simply holds the block in that state.
// Reset (rst, synchronous) returns the block to idle with no result pending.
module trial_division_prime_test import tdpt_pkg::*; #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  tdpt_in_if.sink       cand_ch,
  tdpt_out_if.source    res_ch
);

  localparam int CW = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;
  localparam int SW = $clog2(CW);

  tdpt_state_t     state;
  tdpt_state_t     state_next;
  logic [CW-1:0]   cand;
  logic [CW-1:0]   div;
  logic [CW-1:0]   rem;
  logic [SW-1:0]   step;
  logic            pass_flag;

  logic [CW:0]     rem_shift;
  logic            rem_ge;
  logic [CW:0]     rem_diff;
  logic [CW-1:0]   rem_next;
  logic            div_lt;
  logic            last_step;

  // Shared restoring remainder step: bring in one candidate bit, MSB first.
  assign rem_shift = {rem, cand[step]};
  assign rem_ge    = rem_shift >= {1'b0, div};
  assign rem_diff  = rem_shift - {1'b0, div};
  assign rem_next  = rem_ge ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
  assign div_lt    = div < cand;
  assign last_step = step == '0;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cand_ch.valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = div_lt ? ST_DIVIDE : ST_DONE;
      end
      ST_DIVIDE: begin
        if (last_step) state_next = (rem_next == '0) ? ST_DONE : ST_CHECK;
      end
      ST_DONE: begin
        if (res_ch.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cand_ch.ready       = state == ST_IDLE;
    res_ch.valid        = state == ST_DONE;
    res_ch.passed       = pass_flag;
    res_ch.echoed_value = pass_flag ? FIELD_WIDTH'(cand) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand      <= '0;
      div       <= CW'(FIRST_DIVISOR);
      rem       <= '0;
      step      <= '0;
      pass_flag <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cand_ch.valid) begin
            cand      <= cand_ch.candidate[CW-1:0];
            div       <= CW'(FIRST_DIVISOR);
            pass_flag <= 1'b1;
          end
        end
        ST_CHECK: begin
          rem  <= '0;
          step <= SW'(CW - 1);
        end
        ST_DIVIDE: begin
          rem  <= rem_next;
          step <= step - SW'(1);
          if (last_step) begin
            if (rem_next == '0) begin
              pass_flag <= 1'b0;
            end else begin
              div <= div + CW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The block never takes a new word while a result is still offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cand_ch.ready && res_ch.valid))
    else $error("input ready while a result is pending");

  // Divisors stay in 2..candidate-1 while a division runs.
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (div >= CW'(FIRST_DIVISOR) && div < cand))
    else $error("trial divisor out of range");

  // The partial remainder is always reduced below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (rem < div))
    else $error("partial remainder not reduced");

  // A result appears only after a range check or a finished division.
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_ch.valid) |-> ($past(state) == ST_CHECK || $past(state) == ST_DIVIDE))
    else $error("result raised from an unexpected state");

endmodule

>>> test/trial_division_prime_test_tb.sv
`timescale 1ns / 100ps

module trial_division_prime_test_tb;
  import tdpt_pkg::*;

  localparam int VW = 16;
  localparam int CAND_BITS = (VW < FIELD_WIDTH) ? VW : FIELD_WIDTH;
  localparam int RANDOM_COUNT = 100;

  typedef struct {
    logic [FIELD_WIDTH-1:0] value;
    bit                     hold_for_drain;
  } candidate_item_t;

  typedef struct {
    logic                   passed;
    logic [FIELD_WIDTH-1:0] echoed;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tdpt_in_if  cand_ch ();
  tdpt_out_if res_ch ();

  trial_division_prime_test #(.VALUE_WIDTH(VW)) dut (
    .clk     (clk),
    .rst     (rst),
    .cand_ch (cand_ch.sink),
    .res_ch  (res_ch.source)
  );

  candidate_item_t candidates_queued[$];
  verdict_t        verdicts_due[$];
  int              words_total;
  int              words_sent = 0;
  int              verdicts_seen = 0;
  int              faults = 0;

  always #2 clk = ~clk;

  // Divisor at which trial division stops; equals the candidate for a prime,
  // and stays at the first divisor for candidates below three.
  function automatic int unsigned stop_divisor(logic [FIELD_WIDTH-1:0] raw);
    int unsigned c;
    int unsigned d;
    c = raw & ((1 << CAND_BITS) - 1);
    d = FIRST_DIVISOR;
    while (d < c && (c % d) != 0) d++;
    return d;
  endfunction

  function automatic verdict_t judge_candidate(logic [FIELD_WIDTH-1:0] raw);
    verdict_t    v;
    int unsigned c;
    c = raw & ((1 << CAND_BITS) - 1);
    v.passed = (stop_divisor(raw) >= c);
    v.echoed = v.passed ? FIELD_WIDTH'(c) : '0;
    return v;
  endfunction

  // Sender: one word at a time from the queue, with random gaps except in a
  // calm stretch in the middle of the random part.
  always @(posedge clk) begin
    bit calm;
    bit gap;
    calm = (words_sent >= 45 && words_sent < 75);
    gap  = !calm && ($urandom_range(99) < 35);
    if (rst) begin
      cand_ch.valid <= 1'b0;
    end else begin
      if (cand_ch.valid && cand_ch.ready) begin
        verdicts_due.push_back(judge_candidate(cand_ch.candidate));
        words_sent++;
      end
      if (!cand_ch.valid || cand_ch.ready) begin
        if (candidates_queued.size() > 0 && !gap &&
            !(candidates_queued[0].hold_for_drain && verdicts_due.size() > 0)) begin
          cand_ch.valid     <= 1'b1;
          cand_ch.candidate <= candidates_queued[0].value;
          candidates_queued.pop_front();
        end else begin
          cand_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word against the oldest verdict due.
  always @(posedge clk) begin
    verdict_t want;
    bit       calm;
    calm = (verdicts_seen >= 30 && verdicts_seen < 55);
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        verdicts_seen++;
        if (verdicts_due.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected result word: passed=%0b echoed_value=%0d",
                     res_ch.passed, res_ch.echoed_value);
        end else begin
          want = verdicts_due.pop_front();
          if (res_ch.passed !== want.passed || res_ch.echoed_value !== want.echoed) begin
            faults++;
            if (faults <= 10)
              $display("mismatch on result %0d: got passed=%0b echoed_value=%0d, want passed=%0b echoed_value=%0d",
                       verdicts_seen, res_ch.passed, res_ch.echoed_value,
                       want.passed, want.echoed);
          end
        end
      end
      res_ch.ready <= calm || ($urandom_range(99) >= 35);
    end
  end

  task automatic queue_candidate(logic [FIELD_WIDTH-1:0] value, bit drain = 1'b0);
    candidate_item_t item;
    item.value = value;
    item.hold_for_drain = drain;
    candidates_queued.push_back(item);
  endtask

  initial begin
    logic [FIELD_WIDTH-1:0] pick;
    int                     kind;
    cand_ch.valid = 1'b0;
    cand_ch.candidate = '0;
    res_ch.ready = 1'b0;

    // Small candidates, the no-divisor cases, field extremes and a few
    // composites whose smallest factor sits well above two.
    queue_candidate(16'd0);
    queue_candidate(16'd1);
    queue_candidate(16'd2);
    queue_candidate(16'd3);
    queue_candidate(16'd4);
    queue_candidate(16'd5);
    queue_candidate(16'd49);
    queue_candidate(16'd169);
    queue_candidate(16'd251);
    queue_candidate(16'd253);
    queue_candidate(16'd255);
    queue_candidate(16'd256);
    queue_candidate(16'd4093);
    queue_candidate(16'd32767);
    queue_candidate(16'd32768);
    queue_candidate(16'h5555);
    queue_candidate(16'hAAAA, 1'b1);
    queue_candidate(16'd65533);
    queue_candidate(16'd65534);
    queue_candidate(16'd65535);

    // Random part: mostly small candidates, where primes are cheap; wider
    // ones are kept to a small smallest factor so the run stays short.
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        pick = FIELD_WIDTH'($urandom_range(255));
      end else begin
        pick = (kind < 70) ? FIELD_WIDTH'($urandom_range(4095))
                           : FIELD_WIDTH'($urandom_range(65535));
        if (stop_divisor(pick) > 256) pick[0] = 1'b0;
      end
      queue_candidate(pick, (n == RANDOM_COUNT / 2));
    end
    words_total = candidates_queued.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (words_sent < words_total) @(posedge clk);
    while (verdicts_due.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (faults == 0 && verdicts_due.size() == 0) begin
      $display("trial_division_prime_test_tb: PASS");
    end else begin
      $display("trial_division_prime_test_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("trial_division_prime_test_tb: FAIL");
    $finish;
  end

endmodule
